// ----- hw/rtl/qpit_pkg.sv -----
// qpit_pkg: shared types, constants and the micro-op table for the quad pair
// intersection test. No dependencies.
`timescale 1ns / 1ps

package qpit_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIFF,
        S_MUL,
        S_DRAIN,
        S_NORM,
        S_CHK1,
        S_CHK2,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        B_DIFF,
        B_MLO,
        B_MHI
    } t_bsrc;

    typedef struct packed {
        logic       wr;
        logic [3:0] a;
        t_bsrc      bk;
        logic [3:0] b;
        logic       neg;
        logic [3:0] dst;
    } t_uop;

    // difference register indices
    localparam logic [3:0] D_ABX = 4'd0;
    localparam logic [3:0] D_ABY = 4'd1;
    localparam logic [3:0] D_ABZ = 4'd2;
    localparam logic [3:0] D_ACX = 4'd3;
    localparam logic [3:0] D_ACY = 4'd4;
    localparam logic [3:0] D_ACZ = 4'd5;
    localparam logic [3:0] D_DRX = 4'd6;
    localparam logic [3:0] D_DRY = 4'd7;
    localparam logic [3:0] D_DRZ = 4'd8;
    localparam logic [3:0] D_APX = 4'd9;
    localparam logic [3:0] D_APY = 4'd10;
    localparam logic [3:0] D_APZ = 4'd11;

    // accumulator indices
    localparam logic [3:0] A_M1  = 4'd0;
    localparam logic [3:0] A_M2  = 4'd1;
    localparam logic [3:0] A_M3  = 4'd2;
    localparam logic [3:0] A_M4  = 4'd3;
    localparam logic [3:0] A_M5  = 4'd4;
    localparam logic [3:0] A_M6  = 4'd5;
    localparam logic [3:0] A_DEN = 4'd6;
    localparam logic [3:0] A_NT  = 4'd7;
    localparam logic [3:0] A_NG  = 4'd8;
    localparam logic [3:0] A_NB  = 4'd9;

    localparam int          NUM_DIFF = 12;
    localparam int          NUM_ACC  = 10;
    localparam int          NUM_VTX  = 5;
    localparam logic [5:0]  LAST_STEP = 6'd36;
    localparam logic [2:0]  LAST_LD   = 3'd5;
    localparam logic [3:0]  LAST_TEST = 4'd15;

    function automatic t_uop mk(input logic [3:0] a, input t_bsrc bk,
                                input logic [3:0] b, input logic neg,
                                input logic [3:0] dst);
        t_uop u;
        u.wr  = 1'b1;
        u.a   = a;
        u.bk  = bk;
        u.b   = b;
        u.neg = neg;
        u.dst = dst;
        return u;
    endfunction

    // cofactors first, one idle step, then the four 3x3 determinants as
    // difference times cofactor, each cofactor split into low and high halves
    function automatic t_uop uop_at(input logic [5:0] step);
        t_uop u;
        u = '0;
        unique case (step)
            6'd0:  u = mk(D_ABY, B_DIFF, D_ACZ, 1'b0, A_M1);
            6'd1:  u = mk(D_ABZ, B_DIFF, D_ACY, 1'b1, A_M1);
            6'd2:  u = mk(D_ABY, B_DIFF, D_DRZ, 1'b0, A_M2);
            6'd3:  u = mk(D_ABZ, B_DIFF, D_DRY, 1'b1, A_M2);
            6'd4:  u = mk(D_ABY, B_DIFF, D_APZ, 1'b0, A_M3);
            6'd5:  u = mk(D_ABZ, B_DIFF, D_APY, 1'b1, A_M3);
            6'd6:  u = mk(D_ACY, B_DIFF, D_DRZ, 1'b0, A_M4);
            6'd7:  u = mk(D_ACZ, B_DIFF, D_DRY, 1'b1, A_M4);
            6'd8:  u = mk(D_APY, B_DIFF, D_ACZ, 1'b0, A_M5);
            6'd9:  u = mk(D_APZ, B_DIFF, D_ACY, 1'b1, A_M5);
            6'd10: u = mk(D_APY, B_DIFF, D_DRZ, 1'b0, A_M6);
            6'd11: u = mk(D_APZ, B_DIFF, D_DRY, 1'b1, A_M6);
            6'd12: u = '0;
            6'd13: u = mk(D_ABX, B_MLO, A_M4, 1'b0, A_DEN);
            6'd14: u = mk(D_ABX, B_MHI, A_M4, 1'b0, A_DEN);
            6'd15: u = mk(D_ACX, B_MLO, A_M2, 1'b1, A_DEN);
            6'd16: u = mk(D_ACX, B_MHI, A_M2, 1'b1, A_DEN);
            6'd17: u = mk(D_DRX, B_MLO, A_M1, 1'b0, A_DEN);
            6'd18: u = mk(D_DRX, B_MHI, A_M1, 1'b0, A_DEN);
            6'd19: u = mk(D_ABX, B_MLO, A_M5, 1'b1, A_NT);
            6'd20: u = mk(D_ABX, B_MHI, A_M5, 1'b1, A_NT);
            6'd21: u = mk(D_ACX, B_MLO, A_M3, 1'b1, A_NT);
            6'd22: u = mk(D_ACX, B_MHI, A_M3, 1'b1, A_NT);
            6'd23: u = mk(D_APX, B_MLO, A_M1, 1'b0, A_NT);
            6'd24: u = mk(D_APX, B_MHI, A_M1, 1'b0, A_NT);
            6'd25: u = mk(D_ABX, B_MLO, A_M6, 1'b0, A_NG);
            6'd26: u = mk(D_ABX, B_MHI, A_M6, 1'b0, A_NG);
            6'd27: u = mk(D_APX, B_MLO, A_M2, 1'b1, A_NG);
            6'd28: u = mk(D_APX, B_MHI, A_M2, 1'b1, A_NG);
            6'd29: u = mk(D_DRX, B_MLO, A_M3, 1'b0, A_NG);
            6'd30: u = mk(D_DRX, B_MHI, A_M3, 1'b0, A_NG);
            6'd31: u = mk(D_APX, B_MLO, A_M4, 1'b0, A_NB);
            6'd32: u = mk(D_APX, B_MHI, A_M4, 1'b0, A_NB);
            6'd33: u = mk(D_ACX, B_MLO, A_M6, 1'b1, A_NB);
            6'd34: u = mk(D_ACX, B_MHI, A_M6, 1'b1, A_NB);
            6'd35: u = mk(D_DRX, B_MLO, A_M5, 1'b0, A_NB);
            6'd36: u = mk(D_DRX, B_MHI, A_M5, 1'b0, A_NB);
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

// ----- hw/rtl/qpit_ram.sv -----
// qpit_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module qpit_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/quad_pair_intersection_test.sv -----
// quad_pair_intersection_test: vertex store plus a sequenced segment/triangle
// tester on one shared multiplier. Depends on qpit_pkg and qpit_ram.
//
//   port group          dir  notes
//   start / busy        in/out request: i_slot, i_*_coord, i_evaluate
//   o_valid             out  one-cycle strobe with o_intersects
//
// Item without evaluate: stored in the accept cycle, busy stays low.
// Item with evaluate: per edge/triangle test, 5 vertex reads through the
// single RAM read port, 37 multiplier steps, then normalise and compare; up to
// 16 tests, stopping at the first hit, then the result state S_DONE. Reset
// clears control only; the result cannot be stalled.
`timescale 1ns / 1ps

module quad_pair_intersection_test #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_slot,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [COORD_WIDTH-1:0] i_z_coord,
    input  logic                          i_evaluate,
    output logic                          o_valid,
    output logic                          o_intersects
);

    // the 2^FRAC_BITS scale cancels in every ratio
    localparam int FRAC_UNUSED = FRAC_BITS;
    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW + 2;
    localparam int ACC = 3 * DW + 4;
    localparam int VW  = 3 * CW;

    qpit_pkg::t_state r_state, n_state;

    logic [5:0]  r_step;
    logic [2:0]  r_ld;
    logic [3:0]  r_tst;
    logic        r_hit;
    logic        r_den_nz;
    logic        r_ok1;

    logic signed [CW-1:0]  r_vx [qpit_pkg::NUM_VTX];
    logic signed [CW-1:0]  r_vy [qpit_pkg::NUM_VTX];
    logic signed [CW-1:0]  r_vz [qpit_pkg::NUM_VTX];
    logic signed [DW-1:0]  r_diff [qpit_pkg::NUM_DIFF];
    logic signed [ACC-1:0] r_acc [qpit_pkg::NUM_ACC];
    logic signed [ACC-1:0] r_sum;

    logic signed [PW-1:0]  r_prod;
    logic                  r_pv;
    logic                  r_pneg;
    logic                  r_phi;
    logic [3:0]            r_pdst;

    logic                  w_acc_req;
    logic                  w_we;
    logic [2:0]            w_raddr;
    logic [VW-1:0]         w_rdata;
    logic                  w_dir;
    logic                  w_tri;
    logic [1:0]            w_edge;
    qpit_pkg::t_uop        w_u;
    logic signed [DW:0]    w_ma;
    logic signed [DW:0]    w_mb;
    logic signed [ACC-1:0] w_term;
    logic signed [ACC-1:0] w_den;
    logic                  w_hit;

    assign w_acc_req = start && !busy;
    assign w_we      = w_acc_req;
    assign w_dir     = r_tst[3];
    assign w_edge    = r_tst[2:1];
    assign w_tri     = r_tst[0];

    always_comb begin
        unique case (r_ld)
            3'd0:    w_raddr = {w_dir, w_edge};
            3'd1:    w_raddr = {w_dir, w_edge + 2'd1};
            3'd2:    w_raddr = {~w_dir, 2'd0};
            3'd3:    w_raddr = {~w_dir, 2'd1 + {1'b0, w_tri}};
            default: w_raddr = {~w_dir, 2'd2 + {1'b0, w_tri}};
        endcase
    end

    qpit_ram #(
        .WIDTH (VW),
        .DEPTH (8)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_slot),
        .i_wdata ({i_z_coord, i_y_coord, i_x_coord}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // multiplier operands
    always_comb begin
        w_u  = qpit_pkg::uop_at(r_step);
        w_ma = (DW+1)'(r_diff[w_u.a]);
        unique case (w_u.bk)
            qpit_pkg::B_DIFF: w_mb = (DW+1)'(r_diff[w_u.b]);
            qpit_pkg::B_MLO:  w_mb = {1'b0, r_acc[w_u.b][DW-1:0]};
            qpit_pkg::B_MHI:  w_mb = r_acc[w_u.b][2*DW:DW];
            default:          w_mb = '0;
        endcase
    end

    always_comb begin
        w_term = ACC'(r_prod);
        if (r_phi) begin
            w_term = ACC'(r_prod) <<< DW;
        end
    end

    assign w_den = r_acc[qpit_pkg::A_DEN];
    assign w_hit = r_den_nz && r_ok1 && (r_sum <= w_den);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qpit_pkg::S_IDLE:  if (w_acc_req && i_evaluate) n_state = qpit_pkg::S_LOAD;
            qpit_pkg::S_LOAD:  if (r_ld == qpit_pkg::LAST_LD) n_state = qpit_pkg::S_DIFF;
            qpit_pkg::S_DIFF:  n_state = qpit_pkg::S_MUL;
            qpit_pkg::S_MUL:   if (r_step == qpit_pkg::LAST_STEP) n_state = qpit_pkg::S_DRAIN;
            qpit_pkg::S_DRAIN: n_state = qpit_pkg::S_NORM;
            qpit_pkg::S_NORM:  n_state = qpit_pkg::S_CHK1;
            qpit_pkg::S_CHK1:  n_state = qpit_pkg::S_CHK2;
            qpit_pkg::S_CHK2: begin
                if (w_hit || r_tst == qpit_pkg::LAST_TEST) begin
                    n_state = qpit_pkg::S_DONE;
                end else begin
                    n_state = qpit_pkg::S_LOAD;
                end
            end
            qpit_pkg::S_DONE:  n_state = qpit_pkg::S_IDLE;
            default:           n_state = qpit_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qpit_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld   <= '0;
            r_step <= '0;
            r_tst  <= '0;
            r_hit  <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            unique case (r_state)
                qpit_pkg::S_IDLE: begin
                    r_ld  <= '0;
                    r_tst <= '0;
                    r_hit <= 1'b0;
                end
                qpit_pkg::S_LOAD: begin
                    r_ld <= r_ld + 3'd1;
                end
                qpit_pkg::S_DIFF: begin
                    r_step <= '0;
                end
                qpit_pkg::S_MUL: begin
                    r_step <= r_step + 6'd1;
                    r_pv   <= w_u.wr;
                end
                qpit_pkg::S_CHK2: begin
                    r_ld  <= '0;
                    r_tst <= r_tst + 4'd1;
                    r_hit <= w_hit;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == qpit_pkg::S_LOAD && r_ld != 3'd0) begin
            r_vx[r_ld - 3'd1] <= w_rdata[CW-1:0];
            r_vy[r_ld - 3'd1] <= w_rdata[2*CW-1:CW];
            r_vz[r_ld - 3'd1] <= w_rdata[3*CW-1:2*CW];
        end
        if (r_state == qpit_pkg::S_DIFF) begin
            r_diff[qpit_pkg::D_ABX] <= DW'(r_vx[2]) - DW'(r_vx[3]);
            r_diff[qpit_pkg::D_ABY] <= DW'(r_vy[2]) - DW'(r_vy[3]);
            r_diff[qpit_pkg::D_ABZ] <= DW'(r_vz[2]) - DW'(r_vz[3]);
            r_diff[qpit_pkg::D_ACX] <= DW'(r_vx[2]) - DW'(r_vx[4]);
            r_diff[qpit_pkg::D_ACY] <= DW'(r_vy[2]) - DW'(r_vy[4]);
            r_diff[qpit_pkg::D_ACZ] <= DW'(r_vz[2]) - DW'(r_vz[4]);
            r_diff[qpit_pkg::D_DRX] <= DW'(r_vx[1]) - DW'(r_vx[0]);
            r_diff[qpit_pkg::D_DRY] <= DW'(r_vy[1]) - DW'(r_vy[0]);
            r_diff[qpit_pkg::D_DRZ] <= DW'(r_vz[1]) - DW'(r_vz[0]);
            r_diff[qpit_pkg::D_APX] <= DW'(r_vx[2]) - DW'(r_vx[0]);
            r_diff[qpit_pkg::D_APY] <= DW'(r_vy[2]) - DW'(r_vy[0]);
            r_diff[qpit_pkg::D_APZ] <= DW'(r_vz[2]) - DW'(r_vz[0]);
            for (int i = 0; i < qpit_pkg::NUM_ACC; i++) begin
                r_acc[i] <= '0;
            end
        end
        if (r_state == qpit_pkg::S_MUL) begin
            r_prod <= w_ma * w_mb;
            r_pneg <= w_u.neg;
            r_phi  <= (w_u.bk == qpit_pkg::B_MHI);
            r_pdst <= w_u.dst;
        end
        if (r_pv) begin
            if (r_pneg) begin
                r_acc[r_pdst] <= r_acc[r_pdst] - w_term;
            end else begin
                r_acc[r_pdst] <= r_acc[r_pdst] + w_term;
            end
        end
        if (r_state == qpit_pkg::S_NORM) begin
            r_den_nz <= (w_den != '0);
            if (w_den < 0) begin
                r_acc[qpit_pkg::A_DEN] <= -w_den;
                r_acc[qpit_pkg::A_NT]  <= -r_acc[qpit_pkg::A_NT];
                r_acc[qpit_pkg::A_NG]  <= -r_acc[qpit_pkg::A_NG];
                r_acc[qpit_pkg::A_NB]  <= -r_acc[qpit_pkg::A_NB];
            end
        end
        if (r_state == qpit_pkg::S_CHK1) begin
            r_ok1 <= (r_acc[qpit_pkg::A_NT] >= 0) && (r_acc[qpit_pkg::A_NT] <= w_den)
                  && (r_acc[qpit_pkg::A_NG] >= 0) && (r_acc[qpit_pkg::A_NG] <= w_den)
                  && (r_acc[qpit_pkg::A_NB] >= 0);
            r_sum <= r_acc[qpit_pkg::A_NB] + r_acc[qpit_pkg::A_NG];
        end
    end

    assign busy         = (r_state != qpit_pkg::S_IDLE);
    assign o_valid      = (r_state == qpit_pkg::S_DONE) && (FRAC_UNUSED >= 0);
    assign o_intersects = r_hit;

endmodule
